// ===== hw/rtl/fcte_pkg.sv =====
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types, constants and helpers for the FAT12 cluster table engine.
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W       = 12;
    localparam int COUNT_W       = 13;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 32;

    // entry markers
    localparam logic [ENTRY_W-1:0] MARK_FREE     = 12'h000;
    localparam logic [ENTRY_W-1:0] MARK_RESERVED = 12'hFF0;
    localparam logic [ENTRY_W-1:0] MARK_BAD      = 12'hFF7;
    localparam logic [ENTRY_W-1:0] MARK_END      = 12'hFFF;

    // command codes
    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_ALLOC  = 3'd2;
    localparam logic [2:0] CMD_FREE   = 3'd3;
    localparam logic [2:0] CMD_CENSUS = 3'd4;

    // register indexes
    localparam logic REG_TOTAL_CLUSTERS = 1'b0;
    localparam logic REG_FAT_BYTES      = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic [ENTRY_W-1:0] cluster;
        logic [ENTRY_W-1:0] entry_in;
    } t_in_item;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_out;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] bad_count;
        logic [COUNT_W-1:0] reserved_count;
    } t_out_item;

    typedef struct packed {
        logic [ENTRY_W-1:0] total_clusters;
        logic [12:0]        fat_bytes;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_issue;
        logic rd_eval;
        logic wr_entry;
        logic scan_run;
        logic chain_rd;
        logic chain_ev;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic found;
        logic cur_in_chain;
    } t_dp_stat;

    // cluster lies inside the table and inside the packed fat image
    function automatic logic slot_ok(input logic [12:0] x, input logic [12:0] fb);
        logic [13:0] last_byte;
        last_byte = {1'b0, x} + {2'b00, x[12:1]} + 14'd1;
        return ({1'b0, x} < 14'(TABLE_ENTRIES)) && (last_byte < {1'b0, fb});
    endfunction

endpackage

// ===== hw/rtl/fcte_ram.sv =====
// ----------------------------------------------------------------------------
// fcte_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fcte_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fcte_regs.sv =====
// ----------------------------------------------------------------------------
// fcte_regs
// APB register file holding the cluster count and the fat size.
// ----------------------------------------------------------------------------
module fcte_regs
    import fcte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [ENTRY_W-1:0] r_total_clusters;
    logic [12:0]        r_fat_bytes;
    logic               wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_clusters <= '0;
            r_fat_bytes      <= 13'd2048;
        end else if (wr_en) begin
            case (paddr[2])
                REG_TOTAL_CLUSTERS: r_total_clusters <= pwdata[ENTRY_W-1:0];
                REG_FAT_BYTES:      r_fat_bytes      <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TOTAL_CLUSTERS: prdata = {{(CFG_DW-ENTRY_W){1'b0}}, r_total_clusters};
            REG_FAT_BYTES:      prdata = {{(CFG_DW-13){1'b0}}, r_fat_bytes};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.total_clusters = r_total_clusters;
    assign o_cfg.fat_bytes      = r_fat_bytes;

endmodule

// ===== hw/rtl/fcte_dp.sv =====
// ----------------------------------------------------------------------------
// fcte_dp
// Datapath: table memory, scan pipeline, chain walker, tallies, result register.
// ----------------------------------------------------------------------------
module fcte_dp
    import fcte_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_data
);

    logic [2:0]         r_cmd;
    logic [ENTRY_W-1:0] r_cluster;
    logic [ENTRY_W-1:0] r_entry_in;
    logic [ENTRY_W-1:0] r_cur;
    logic [12:0]        r_scan_c;
    logic [12:0]        r_pipe_c;
    logic               r_pipe_v;
    logic [TBL_AW-1:0]  r_clr_a;
    logic [ENTRY_W-1:0] r_eout;
    logic [COUNT_W-1:0] r_nfree;
    logic [COUNT_W-1:0] r_nused;
    logic [COUNT_W-1:0] r_nbad;
    logic [COUNT_W-1:0] r_nres;
    t_out_item          r_out;

    logic               we;
    logic [TBL_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [TBL_AW-1:0]  raddr;
    logic [ENTRY_W-1:0] rd_data;

    logic [12:0]        limit;
    logic               scan_issue;
    logic               pipe_ok;
    logic [ENTRY_W-1:0] pipe_e;
    logic               found;
    logic               census_hit;
    logic               cl_ok;
    logic               cur_ok;
    logic [ENTRY_W-1:0] chain_next;

    assign limit      = {1'b0, i_cfg.total_clusters} + 13'd2;
    assign scan_issue = i_cmd.scan_run && (r_scan_c < limit);
    assign pipe_ok    = slot_ok(r_pipe_c, i_cfg.fat_bytes);
    assign pipe_e     = pipe_ok ? rd_data : MARK_END;
    assign found      = i_cmd.scan_run && r_pipe_v && (r_cmd == CMD_ALLOC)
                        && (pipe_e == MARK_FREE);
    assign census_hit = i_cmd.scan_run && r_pipe_v && (r_cmd == CMD_CENSUS);
    assign cl_ok      = slot_ok({1'b0, r_cluster}, i_cfg.fat_bytes);
    assign cur_ok     = slot_ok({1'b0, r_cur}, i_cfg.fat_bytes);
    assign chain_next = cur_ok ? rd_data : MARK_END;

    // write port arbitration
    always_comb begin
        we    = 1'b0;
        waddr = r_scan_c[TBL_AW-1:0];
        wdata = MARK_FREE;
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            waddr = r_clr_a;
        end else if (i_cmd.wr_entry) begin
            we    = cl_ok;
            waddr = r_cluster[TBL_AW-1:0];
            wdata = r_entry_in;
        end else if (found) begin
            we    = 1'b1;
            waddr = r_pipe_c[TBL_AW-1:0];
            wdata = MARK_END;
        end else if (i_cmd.chain_ev) begin
            we    = cur_ok;
            waddr = r_cur[TBL_AW-1:0];
        end
    end

    always_comb begin
        if (i_cmd.rd_issue) begin
            raddr = r_cluster[TBL_AW-1:0];
        end else if (i_cmd.chain_rd) begin
            raddr = r_cur[TBL_AW-1:0];
        end else begin
            raddr = r_scan_c[TBL_AW-1:0];
        end
    end

    fcte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_a  <= '0;
            r_pipe_v <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_a <= r_clr_a + 1'b1;
            end
            if (i_cmd.accept) begin
                r_pipe_v <= 1'b0;
            end else begin
                r_pipe_v <= scan_issue;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= i_in_data.command;
            r_cluster  <= i_in_data.cluster;
            r_entry_in <= i_in_data.entry_in;
            r_cur      <= i_in_data.cluster;
            r_scan_c   <= 13'd2;
            r_eout     <= '0;
            r_nfree    <= '0;
            r_nused    <= '0;
            r_nbad     <= '0;
            r_nres     <= '0;
        end else begin
            if (scan_issue) begin
                r_pipe_c <= r_scan_c;
                r_scan_c <= r_scan_c + 13'd1;
            end
            if (i_cmd.rd_eval) begin
                r_eout <= cl_ok ? rd_data : MARK_END;
            end
            if (found) begin
                r_eout <= r_pipe_c[ENTRY_W-1:0];
            end
            if (i_cmd.chain_ev) begin
                r_cur <= chain_next;
            end
            if (census_hit) begin
                if (pipe_e == MARK_FREE) begin
                    r_nfree <= r_nfree + 1'b1;
                end else if (pipe_e == MARK_BAD) begin
                    r_nbad <= r_nbad + 1'b1;
                end else if (pipe_e >= MARK_RESERVED && pipe_e < MARK_BAD) begin
                    r_nres <= r_nres + 1'b1;
                end else begin
                    r_nused <= r_nused + 1'b1;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out.entry_out      <= r_eout;
            r_out.free_count     <= r_nfree;
            r_out.used_count     <= r_nused;
            r_out.bad_count      <= r_nbad;
            r_out.reserved_count <= r_nres;
        end
    end

    assign o_stat.clr_last     = (r_clr_a == TBL_AW'(TABLE_ENTRIES - 1));
    assign o_stat.scan_done    = !r_pipe_v && !(r_scan_c < limit);
    assign o_stat.found        = found;
    assign o_stat.cur_in_chain = (r_cur >= 12'd2) && (r_cur < MARK_RESERVED);
    assign o_out_data          = r_out;

endmodule

// ===== hw/rtl/fcte_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcte_ctrl
// Controller: sequences the clearing pass and each command, owns the handshakes.
// ----------------------------------------------------------------------------
module fcte_ctrl
    import fcte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_command,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_RD       = 9'b000000100,
        S_RD_EV    = 9'b000001000,
        S_WR       = 9'b000010000,
        S_SCAN     = 9'b000100000,
        S_CHAIN_RD = 9'b001000000,
        S_CHAIN_EV = 9'b010000000,
        S_FIN      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && i_out_stall;
        o_cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_command)
                        CMD_READ:   n_state = S_RD;
                        CMD_WRITE:  n_state = S_WR;
                        CMD_ALLOC:  n_state = S_SCAN;
                        CMD_FREE:   n_state = S_CHAIN_RD;
                        CMD_CENSUS: n_state = S_SCAN;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_EV;
            end
            S_RD_EV: begin
                o_cmd.rd_eval = 1'b1;
                n_state       = S_FIN;
            end
            S_WR: begin
                o_cmd.wr_entry = 1'b1;
                n_state        = S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.found || i_stat.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_CHAIN_RD: begin
                if (i_stat.cur_in_chain) begin
                    o_cmd.chain_rd = 1'b1;
                    n_state        = S_CHAIN_EV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHAIN_EV: begin
                o_cmd.chain_ev = 1'b1;
                n_state        = S_CHAIN_RD;
            end
            S_FIN: begin
                // wait for the output register to drain
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// ===== hw/rtl/fat12_cluster_table_engine.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine
// FAT12 allocation table with read, write, allocate, free-chain and census.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry table to free, one entry per
// cycle, and holds o_in_stall high for the whole sweep; APB writes are taken
// throughout. Then one command is in flight at a time and every command gives
// one result transfer. Allocate and census scan clusters 2 to total_clusters
// + 1, streaming one table read per cycle through the single read port, and
// allocate stops at the first free cluster. Free chain reads and frees the
// chain link by link.
// The result sits in an output register, so the next command can be accepted
// while the previous result is still stalled downstream.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine
    import fcte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg     cfg;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fcte_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcte_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    fcte_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule
